[rtl/core/dlfp_pkg.sv]
// shared constants, types and helpers of the decimal line field parser
package dlfp_pkg;

    localparam int MAX_VALUES = 8;
    localparam int IDX_W      = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
    localparam int CNT_W      = $clog2(MAX_VALUES + 1);
    localparam int VAL_W      = 32;
    localparam int CFG_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int MISS_W     = 16;

    localparam logic [CFG_W-1:0] VALUES_IN_USE_RST = 7'd8;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [1:0] PH_GAP    = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] data;
    } pend_wr_t;

    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] count;
    } line_end_t;

    // register value clamped to 1..MAX_VALUES
    function automatic logic [CNT_W-1:0] slots_active(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > MAX_VALUES) begin
            r = CNT_W'(MAX_VALUES);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

endpackage

[rtl/core/dlfp_scanner.sv]
// byte-level tokeniser: builds numbers and emits pending slot writes and line ends
module dlfp_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_en,
    input  logic [7:0]                    rx_byte,
    input  logic [dlfp_pkg::CNT_W-1:0]    slots,
    output dlfp_pkg::pend_wr_t            pend_wr,
    output dlfp_pkg::line_end_t           line_end
);

    logic [dlfp_pkg::VAL_W-1:0] acc_reg, acc_next;
    logic                       neg_reg, neg_next;
    logic [1:0]                 phase_reg, phase_next;
    logic                       stop_reg, stop_next;
    logic [dlfp_pkg::CNT_W-1:0] pcnt_reg, pcnt_next;

    logic [dlfp_pkg::VAL_W-1:0] close_val;
    logic                       close_wr;
    logic [dlfp_pkg::CNT_W-1:0] close_cnt;
    logic                       close_stop;
    logic [dlfp_pkg::VAL_W-1:0] acc_base;
    logic [dlfp_pkg::VAL_W-1:0] acc_step;
    logic [7:0]                 digit;

    // finished token value and where it goes
    assign close_val  = neg_reg ? (dlfp_pkg::VAL_W'(0) - acc_reg) : acc_reg;
    assign close_wr   = (pcnt_reg < slots);
    assign close_cnt  = pcnt_reg + dlfp_pkg::CNT_W'(close_wr);
    assign close_stop = (close_cnt >= slots);

    // acc * 10 + digit, wrapping at 32 bits
    assign digit    = rx_byte - dlfp_pkg::CH_0;
    assign acc_base = (phase_reg == dlfp_pkg::PH_DIGITS) ? acc_reg : '0;
    assign acc_step = (acc_base << 3) + (acc_base << 1) + {24'd0, digit};

    always_comb begin
        acc_next      = acc_reg;
        neg_next      = neg_reg;
        phase_next    = phase_reg;
        stop_next     = stop_reg;
        pcnt_next     = pcnt_reg;
        pend_wr.en    = 1'b0;
        pend_wr.idx   = pcnt_reg[dlfp_pkg::IDX_W-1:0];
        pend_wr.data  = close_val;
        line_end.en   = 1'b0;
        line_end.count = pcnt_reg;

        if (byte_en) begin
            if (rx_byte == dlfp_pkg::CH_NL) begin
                line_end.en = 1'b1;
                if (!stop_reg && phase_reg == dlfp_pkg::PH_DIGITS) begin
                    pend_wr.en     = close_wr;
                    line_end.count = close_cnt;
                end
                acc_next   = '0;
                neg_next   = 1'b0;
                phase_next = dlfp_pkg::PH_GAP;
                stop_next  = 1'b0;
                pcnt_next  = '0;
            end else if (!stop_reg) begin
                if (rx_byte inside {dlfp_pkg::CH_SP, dlfp_pkg::CH_TAB, dlfp_pkg::CH_CR,
                                    dlfp_pkg::CH_VT, dlfp_pkg::CH_FF}) begin
                    if (phase_reg == dlfp_pkg::PH_DIGITS) begin
                        pend_wr.en = close_wr;
                        pcnt_next  = close_cnt;
                        stop_next  = close_stop;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        phase_next = dlfp_pkg::PH_GAP;
                    end else if (phase_reg == dlfp_pkg::PH_SIGN) begin
                        stop_next = 1'b1;
                    end
                end else if (rx_byte inside {[dlfp_pkg::CH_0:dlfp_pkg::CH_9]}) begin
                    acc_next   = acc_step;
                    phase_next = dlfp_pkg::PH_DIGITS;
                end else if (rx_byte inside {dlfp_pkg::CH_PLUS, dlfp_pkg::CH_MINUS}) begin
                    if (phase_reg == dlfp_pkg::PH_DIGITS) begin
                        // sign right after digits closes the number first
                        pend_wr.en = close_wr;
                        pcnt_next  = close_cnt;
                        stop_next  = close_stop;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        phase_next = dlfp_pkg::PH_GAP;
                        if (!close_stop) begin
                            neg_next   = (rx_byte == dlfp_pkg::CH_MINUS);
                            phase_next = dlfp_pkg::PH_SIGN;
                        end
                    end else if (phase_reg == dlfp_pkg::PH_SIGN) begin
                        stop_next = 1'b1;
                    end else begin
                        neg_next   = (rx_byte == dlfp_pkg::CH_MINUS);
                        acc_next   = '0;
                        phase_next = dlfp_pkg::PH_SIGN;
                    end
                end else begin
                    // malformed byte: keep digits so far, drop rest of line
                    if (phase_reg == dlfp_pkg::PH_DIGITS) begin
                        pend_wr.en = close_wr;
                        pcnt_next  = close_cnt;
                        acc_next   = '0;
                        neg_next   = 1'b0;
                        phase_next = dlfp_pkg::PH_GAP;
                    end
                    stop_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            phase_reg <= dlfp_pkg::PH_GAP;
            stop_reg  <= 1'b0;
            pcnt_reg  <= '0;
        end else begin
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            phase_reg <= phase_next;
            stop_reg  <= stop_next;
            pcnt_reg  <= pcnt_next;
        end
    end

endmodule

[rtl/core/decimal_line_field_parser.sv]
// top level of the decimal line field parser: value stores, commit walk and fetch output
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  -----------------------------------------
//  s_        in         s_valid / s_ready      s_func, s_rx_byte
//  m_        out        m_valid / m_ready      m_slot_index, m_slot_value, m_missed_count,
//                                              m_last
//  cfg_      in         cfg_valid / cfg_ready  cfg_wdata (values_in_use)
//
// a newline walks the pending store into the committed store, one slot read a cycle with
// each write in the cycle after its read
// a fetch reads the committed store once per slot in use; each result is a read of the
// store followed by a load of the result register once that register is free
// s_ready is low during the commit walk and the fetch walk; the output register lets
// the next transaction in while the final result still waits for m_ready
// aresetn is synchronous, active low; the committed store reads as zero until written,
// through one valid bit per slot, so no clearing pass is needed
module decimal_line_field_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input transactions
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [7:0]                          s_rx_byte,
    // result transactions
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [dlfp_pkg::SLOT_W-1:0]         m_slot_index,
    output logic signed [dlfp_pkg::VAL_W-1:0]   m_slot_value,
    output logic [dlfp_pkg::MISS_W-1:0]         m_missed_count,
    output logic                                m_last,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlfp_pkg::CFG_W-1:0]          cfg_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_COMMIT = 2'd1;
    localparam logic [1:0] ST_FRD    = 2'd2;
    localparam logic [1:0] ST_FWAIT  = 2'd3;

    localparam int IDX_W  = dlfp_pkg::IDX_W;
    localparam int CNT_W  = dlfp_pkg::CNT_W;
    localparam int VAL_W  = dlfp_pkg::VAL_W;

    logic [1:0]                  state_reg, state_next;
    logic [dlfp_pkg::CFG_W-1:0]  vin_reg, vin_next;
    logic [CNT_W-1:0]            slots;

    // commit walk
    logic [CNT_W-1:0]            cp_reg, cp_next;
    logic [CNT_W-1:0]            total_reg, total_next;
    logic                        cw_vld_reg, cw_vld_next;
    logic [IDX_W-1:0]            cw_idx_reg, cw_idx_next;
    logic                        pend_rd;

    // fetch walk
    logic [IDX_W-1:0]            fi_reg, fi_next;
    logic                        com_rd;
    logic                        fetch_last;
    logic                        out_load;

    logic                        fresh_reg, fresh_next;
    logic [dlfp_pkg::MISS_W-1:0] miss_reg, miss_next;

    logic                        m_valid_reg, m_valid_next;
    logic [dlfp_pkg::SLOT_W-1:0] m_idx_reg;
    logic [VAL_W-1:0]            m_val_reg;
    logic [dlfp_pkg::MISS_W-1:0] m_miss_reg;
    logic                        m_last_reg;

    // value stores
    logic [VAL_W-1:0]            pend_mem [dlfp_pkg::MAX_VALUES];
    logic [VAL_W-1:0]            com_mem  [dlfp_pkg::MAX_VALUES];
    logic [dlfp_pkg::MAX_VALUES-1:0] com_vld_reg;
    logic [VAL_W-1:0]            pend_q;
    logic [VAL_W-1:0]            com_q;
    logic                        com_vq_reg;

    logic                        s_acc;
    logic                        byte_en;
    dlfp_pkg::pend_wr_t          pend_wr;
    dlfp_pkg::line_end_t         line_end;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_acc     = s_valid && s_ready;
    assign byte_en   = s_acc && !s_func;
    assign slots     = dlfp_pkg::slots_active(vin_reg);

    dlfp_scanner u_scanner (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_en  (byte_en),
        .rx_byte  (s_rx_byte),
        .slots    (slots),
        .pend_wr  (pend_wr),
        .line_end (line_end)
    );

    // commit walk: read pending slot, write it to committed store in the next cycle
    assign pend_rd = (state_reg == ST_COMMIT) && (cp_reg < total_reg);

    // fetch walk: read committed slot, hand it to the output register
    assign com_rd     = (state_reg == ST_FRD);
    assign fetch_last = ({{(CNT_W-IDX_W){1'b0}}, fi_reg} == (slots - CNT_W'(1)));
    assign out_load   = (state_reg == ST_FWAIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        vin_next     = vin_reg;
        cp_next      = cp_reg;
        total_next   = total_reg;
        cw_vld_next  = pend_rd;
        cw_idx_next  = cp_reg[IDX_W-1:0];
        fi_next      = fi_reg;
        fresh_next   = fresh_reg;
        miss_next    = miss_reg;
        m_valid_next = m_valid_reg;

        if (cfg_valid && cfg_ready) begin
            vin_next = cfg_wdata;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_func) begin
                    // fetch transaction
                    if (fresh_reg) begin
                        miss_next = '0;
                    end else if (miss_reg != '1) begin
                        miss_next = miss_reg + dlfp_pkg::MISS_W'(1);
                    end
                    fresh_next = 1'b0;
                    fi_next    = '0;
                    state_next = ST_FRD;
                end else if (line_end.en) begin
                    fresh_next = 1'b1;
                    cp_next    = '0;
                    total_next = line_end.count;
                    if (line_end.count != '0) begin
                        state_next = ST_COMMIT;
                    end
                end
            end
            ST_COMMIT: begin
                if (pend_rd) begin
                    cp_next = cp_reg + CNT_W'(1);
                end else if (!cw_vld_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FRD: begin
                state_next = ST_FWAIT;
            end
            ST_FWAIT: begin
                if (out_load) begin
                    if (fetch_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        fi_next    = fi_reg + IDX_W'(1);
                        state_next = ST_FRD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vin_reg     <= dlfp_pkg::VALUES_IN_USE_RST;
            cp_reg      <= '0;
            total_reg   <= '0;
            cw_vld_reg  <= 1'b0;
            fi_reg      <= '0;
            fresh_reg   <= 1'b0;
            miss_reg    <= '0;
            m_valid_reg <= 1'b0;
            com_vld_reg <= '0;
            com_vq_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            vin_reg     <= vin_next;
            cp_reg      <= cp_next;
            total_reg   <= total_next;
            cw_vld_reg  <= cw_vld_next;
            fi_reg      <= fi_next;
            fresh_reg   <= fresh_next;
            miss_reg    <= miss_next;
            m_valid_reg <= m_valid_next;
            if (cw_vld_reg) begin
                com_vld_reg[cw_idx_reg] <= 1'b1;
            end
            if (com_rd) begin
                com_vq_reg <= com_vld_reg[fi_reg];
            end
        end
    end

    // write index of the commit pipe
    always_ff @(posedge aclk) begin
        cw_idx_reg <= cw_idx_next;
    end

    // pending store
    always_ff @(posedge aclk) begin
        if (pend_wr.en) begin
            pend_mem[pend_wr.idx] <= pend_wr.data;
        end
        if (pend_rd) begin
            pend_q <= pend_mem[cp_reg[IDX_W-1:0]];
        end
    end

    // committed store
    always_ff @(posedge aclk) begin
        if (cw_vld_reg) begin
            com_mem[cw_idx_reg] <= pend_q;
        end
        if (com_rd) begin
            com_q <= com_mem[fi_reg];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_idx_reg  <= {{(dlfp_pkg::SLOT_W-IDX_W){1'b0}}, fi_reg};
            m_val_reg  <= com_vq_reg ? com_q : '0;
            m_miss_reg <= miss_reg;
            m_last_reg <= fetch_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slot_index   = m_idx_reg;
    assign m_slot_value   = $signed(m_val_reg);
    assign m_missed_count = m_miss_reg;
    assign m_last         = m_last_reg;

endmodule
